// ===== src/ptst_pkg.sv =====
// Shared constants, codes and record types of the periodic task slot timer.
package ptst_pkg;

	localparam int SLOTS_DEF   = 16;
	localparam int MAX_RESULTS = 16;

	localparam int KIND_W   = 2;
	localparam int ID_W     = 16;
	localparam int PERIOD_W = 24;
	localparam int TICK_W   = 32;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 4;
	localparam int LATE_W   = 31;

	localparam logic [TICK_W-1:0] POLL_TICK_RST = '1;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_POLL   = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED    = 3'd0,
		ST_FULL     = 3'd1,
		ST_REMOVED  = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FIRED    = 3'd4,
		ST_IDLE     = 3'd5
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]     task_id;
		logic [PERIOD_W-1:0] period;
		logic [TICK_W-1:0]   due;
	} slot_ent_t;

	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   slot;
		logic [ID_W-1:0]     fired_id;
		logic [LATE_W-1:0]   lateness;
		logic                last;
	} rsp_t;

endpackage

// ===== src/ptst_req_if.sv =====
// Request channel interface of the periodic task slot timer.
interface ptst_req_if import ptst_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic [ID_W-1:0]          task_id;
	logic [PERIOD_W-1:0]      period;
	logic [PERIOD_W-1:0]      start_delay;
	logic signed [TICK_W-1:0] now;

	modport source (output valid, kind, task_id, period, start_delay, now, input ready);
	modport sink (input valid, kind, task_id, period, start_delay, now, output ready);
endinterface

// ===== src/ptst_rsp_if.sv =====
// Result channel interface of the periodic task slot timer.
interface ptst_rsp_if import ptst_pkg::*;;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic [ID_W-1:0]     fired_id;
	logic [LATE_W-1:0]   lateness;
	logic                last;

	modport source (output valid, status, slot, fired_id, lateness, last, input ready);
	modport sink (input valid, status, slot, fired_id, lateness, last, output ready);
endinterface

// ===== src/periodic_task_slot_timer_core.sv =====
// Top level of the periodic task slot timer: request decode, slot scan and result queue.
//
// The block keeps SLOTS task slots in a synchronous memory with one read and one write
// port and walks them one entry per cycle while the result side keeps up with fired
// tasks. An add, a remove or a poll at a new tick reads every slot through the one
// read port of the slot memory before its final transaction; a poll may be held up
// while the result side holds off fired tasks. An add or remove with task id zero, a
// poll at the same tick as the previous one and the unused kind code are answered
// without a scan. Reset empties the table at once, so no clearing pass is needed. A new
// request is taken as soon as the final result sits in the output register.
module periodic_task_slot_timer_core import ptst_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	ptst_req_if.sink   req,
	ptst_rsp_if.source rsp
);

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int FCNT_W = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} state_t;

	state_t              state_q;
	logic [KIND_W-1:0]   kind_q;
	logic                skip_q;
	logic [ID_W-1:0]     id_q;
	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] delay_q;
	logic [TICK_W-1:0]   now_q;
	logic [TICK_W-1:0]   last_poll_q;
	logic [CNT_W-1:0]    rd_cnt_q;
	logic                v_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                match_v_q;
	logic [IDX_W-1:0]    match_idx_q;
	slot_ent_t           match_ent_q;
	logic                empty_v_q;
	logic [IDX_W-1:0]    empty_idx_q;
	logic                pend_v_q;
	rsp_t                pend_q;
	logic [FCNT_W-1:0]   fire_cnt_q;
	logic                out_v_q;
	rsp_t                out_q;

	slot_ent_t           ent;
	logic [TICK_W-1:0]   diff;
	logic                hit;
	logic                is_empty;
	logic                fire;
	logic                out_free;
	logic                eval_go;
	logic                advance;
	logic                issue;
	logic                scan_push;
	logic                fin_push;
	rsp_t                fin_rsp;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	slot_ent_t           mem_wdata;
	logic                req_skip;

	ptst_slot_mem #(
		.SLOTS(SLOTS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (issue),
		.rd_addr (rd_cnt_q[IDX_W-1:0]),
		.rd_ent  (ent),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_ent  (mem_wdata)
	);

	assign out_free = !out_v_q || rsp.ready;
	assign diff     = now_q - ent.due;
	assign hit      = (ent.task_id == id_q);
	assign is_empty = (ent.task_id == '0);
	assign fire     = (kind_q == KIND_POLL) && !is_empty && !diff[TICK_W-1]
		&& (fire_cnt_q < FCNT_W'(MAX_RESULTS));
	assign eval_go  = (state_q == S_SCAN) && v_s1 && (!fire || !pend_v_q || out_free);
	assign advance  = !v_s1 || eval_go;
	assign issue    = (state_q == S_SCAN) && advance && (rd_cnt_q != CNT_W'(SLOTS));
	assign scan_push = eval_go && fire && pend_v_q;
	assign fin_push  = (state_q == S_FIN) && out_free;

	assign req_skip = (req.kind == KIND_ADD && req.task_id == '0)
		|| (req.kind == KIND_REMOVE && req.task_id == '0)
		|| !(req.kind inside {KIND_ADD, KIND_REMOVE, KIND_POLL})
		|| (req.kind == KIND_POLL && req.now == last_poll_q);

	always_comb begin
		fin_rsp        = '0;
		fin_rsp.status = ST_IDLE;
		fin_rsp.last   = 1'b1;
		if (skip_q) begin
			case (kind_q)
				KIND_ADD: fin_rsp.status = ST_FULL;
				KIND_REMOVE: fin_rsp.status = ST_NOTFOUND;
				default: fin_rsp.status = ST_IDLE;
			endcase
		end else begin
			case (kind_q)
				KIND_ADD: begin
					if (match_v_q) begin
						fin_rsp.status = ST_ADDED;
						fin_rsp.slot   = SLOT_W'(match_idx_q);
					end else if (empty_v_q) begin
						fin_rsp.status = ST_ADDED;
						fin_rsp.slot   = SLOT_W'(empty_idx_q);
					end else begin
						fin_rsp.status = ST_FULL;
					end
				end
				KIND_REMOVE: begin
					if (match_v_q) begin
						fin_rsp.status = ST_REMOVED;
						fin_rsp.slot   = SLOT_W'(match_idx_q);
					end else begin
						fin_rsp.status = ST_NOTFOUND;
					end
				end
				KIND_POLL: begin
					if (pend_v_q) begin
						fin_rsp      = pend_q;
						fin_rsp.last = 1'b1;
					end
				end
				default: fin_rsp.status = ST_IDLE;
			endcase
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = ent;
		if (eval_go && fire) begin
			mem_we        = 1'b1;
			mem_wdata.due = now_q + TICK_W'(ent.period);
		end else if (fin_push && !skip_q) begin
			case (kind_q)
				KIND_ADD: begin
					mem_we            = match_v_q || empty_v_q;
					mem_waddr         = match_v_q ? match_idx_q : empty_idx_q;
					mem_wdata.task_id = id_q;
					mem_wdata.period  = period_q;
					mem_wdata.due     = now_q + TICK_W'(delay_q);
				end
				KIND_REMOVE: begin
					mem_we            = match_v_q;
					mem_waddr         = match_idx_q;
					mem_wdata         = match_ent_q;
					mem_wdata.task_id = '0;
				end
				default: mem_we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_poll_q <= POLL_TICK_RST;
			rd_cnt_q    <= '0;
			v_s1        <= 1'b0;
			match_v_q   <= 1'b0;
			empty_v_q   <= 1'b0;
			pend_v_q    <= 1'b0;
			fire_cnt_q  <= '0;
			out_v_q     <= 1'b0;
			skip_q      <= 1'b0;
			kind_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						kind_q     <= req.kind;
						id_q       <= req.task_id;
						period_q   <= req.period;
						delay_q    <= req.start_delay;
						now_q      <= req.now;
						skip_q     <= req_skip;
						rd_cnt_q   <= '0;
						v_s1       <= 1'b0;
						match_v_q  <= 1'b0;
						empty_v_q  <= 1'b0;
						pend_v_q   <= 1'b0;
						fire_cnt_q <= '0;
						if (req.kind == KIND_POLL && !req_skip) begin
							last_poll_q <= req.now;
						end
						state_q <= req_skip ? S_FIN : S_SCAN;
					end
				end
				S_SCAN: begin
					if (advance) begin
						v_s1   <= issue;
						idx_s1 <= rd_cnt_q[IDX_W-1:0];
					end
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
					if (eval_go) begin
						if (hit && !match_v_q) begin
							match_v_q   <= 1'b1;
							match_idx_q <= idx_s1;
							match_ent_q <= ent;
						end
						if (is_empty && !empty_v_q) begin
							empty_v_q   <= 1'b1;
							empty_idx_q <= idx_s1;
						end
						if (fire) begin
							pend_v_q          <= 1'b1;
							pend_q.status     <= ST_FIRED;
							pend_q.slot       <= SLOT_W'(idx_s1);
							pend_q.fired_id   <= ent.task_id;
							pend_q.lateness   <= diff[LATE_W-1:0];
							pend_q.last       <= 1'b0;
							fire_cnt_q        <= fire_cnt_q + FCNT_W'(1);
						end
					end
					if (rd_cnt_q == CNT_W'(SLOTS) && !v_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (scan_push) begin
				out_v_q <= 1'b1;
				out_q   <= pend_q;
			end else if (fin_push) begin
				out_v_q <= 1'b1;
				out_q   <= fin_rsp;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign req.ready    = (state_q == S_IDLE);
	assign rsp.valid    = out_v_q;
	assign rsp.status   = out_q.status;
	assign rsp.slot     = out_q.slot;
	assign rsp.fired_id = out_q.fired_id;
	assign rsp.lateness = out_q.lateness;
	assign rsp.last     = out_q.last;

	a_fire_limit: assert property (@(posedge clk) disable iff (!arst_n)
		fire_cnt_q <= FCNT_W'(MAX_RESULTS))
		else $error("More fired tasks than one poll may report.");

	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q)
		else $error("A fired task is still held while no request is in progress.");

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		fin_push |=> (state_q == S_IDLE) && out_v_q && out_q.last)
		else $error("The final transaction did not close the request.");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q != S_IDLE))
		else $error("Slot memory written while no request is in progress.");

endmodule

// ===== src/ptst_slot_mem.sv =====
// Slot table memory with a registered read port and per-entry valid bits cleared by reset.
module ptst_slot_mem import ptst_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(SLOTS)-1:0] rd_addr,
	output slot_ent_t                rd_ent,
	input  logic                     wr_en,
	input  logic [$clog2(SLOTS)-1:0] wr_addr,
	input  slot_ent_t                wr_ent
);

	slot_ent_t        mem [SLOTS];
	slot_ent_t        rdata_q;
	logic [SLOTS-1:0] valid_q;
	logic             rvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvalid_q <= valid_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_ent;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// An entry never written since reset reads as an empty slot.
	assign rd_ent = rvalid_q ? rdata_q : '0;

endmodule
